[rtl/sac_pkg.sv]
// Package for the set-associative read cache.
// Holds operation and size codes and default geometry; no dependencies.
package sac_pkg;

  localparam int unsigned DefSets     = 4;
  localparam int unsigned DefWays     = 2;
  localparam int unsigned DefLineBytes = 8;
  localparam int unsigned DefMemWords = 128;

  localparam int unsigned AddrW = 9;
  localparam int unsigned PreIdxW = 7;
  localparam logic [31:0] MissPenalty = 32'd100;
  localparam logic [7:0] ByteMask = 8'hFF;

  typedef enum logic {
    OP_READ    = 1'b0,
    OP_PRELOAD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_NONE = 2'd3
  } size_t_t;

endpackage

[rtl/set_assoc_lru_read_cache.sv]
// Top level of the set-associative LRU read cache with its backing word memory.
// Depends on sac_pkg for codes and default geometry.
//
// One beat in, one beat out. The block takes one beat at a time. A preload
// goes from acceptance straight to data assembly. A read hit passes through
// accept, tag lookup and victim choice, read of the low line word, read of
// the high line word, and data assembly. A miss adds a line fill after the
// lookup, in which the single read port of the backing memory supplies one
// word of the line per cycle. The output register lets the next beat be
// accepted and processed while a result still waits. That beat then holds in
// data assembly until the output register is free. The way state is held in
// flip-flops with reset. Line data and backing memory are synchronous
// memories without reset, so no clearing pass is needed.
module set_assoc_lru_read_cache #(
  parameter int unsigned SETS       = sac_pkg::DefSets,
  parameter int unsigned WAYS       = sac_pkg::DefWays,
  parameter int unsigned LINE_BYTES = sac_pkg::DefLineBytes,
  parameter int unsigned MEM_WORDS  = sac_pkg::DefMemWords
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [8:0]  byte_address,
  input  logic [1:0]  access_size,
  input  logic [6:0]  preload_index,
  input  logic [31:0] preload_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] read_data,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] bytes_total,
  output logic [31:0] cycle_total
);
  import sac_pkg::*;

  localparam int unsigned LW    = LINE_BYTES / 4;
  localparam int unsigned OffW  = $clog2(LINE_BYTES);
  localparam int unsigned WOffW = (LW > 1) ? $clog2(LW) : 1;
  localparam int unsigned SetW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned MemW  = $clog2(MEM_WORDS);
  localparam int unsigned LDep  = SETS * WAYS * LW;
  localparam int unsigned LAW   = $clog2(LDep);
  localparam int unsigned BlkW  = AddrW - OffW;
  localparam int unsigned TagW  = BlkW - $clog2(SETS);
  localparam int unsigned WCntW = $clog2(LW + 1);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_FILL, S_READ, S_HIGH, S_DATA} state_t;
  state_t state;

  // Way state in flip-flops.
  logic [WAYS-1:0] vld [SETS];
  logic [TagW-1:0] tags [SETS][WAYS];
  logic [31:0]     stamps [SETS][WAYS];
  logic [31:0]     stamp_ctr;

  // Memories.
  logic [31:0] bmem [MEM_WORDS];
  logic [31:0] lmem [LDep];
  logic [31:0] bmem_q, lmem_q;
  logic [MemW-1:0] bmem_ra;
  logic [LAW-1:0]  lmem_ra;
  logic            lmem_we;
  logic [LAW-1:0]  lmem_wa;

  // Captured request.
  logic [8:0]       addr;
  logic [1:0]       size;
  logic [SetW-1:0]  set_q;
  logic [TagW-1:0]  tag_q;
  logic [WayW-1:0]  way_q;
  logic             hit_q;
  logic [WCntW-1:0] fcnt;
  logic             fvalid;
  logic [WOffW-1:0] fidx;
  logic [31:0]      lo_word;

  logic [31:0] hit_ctr, miss_ctr, byte_ctr, cyc_ctr;

  // Block of the captured request and set and tag of the incoming beat.
  logic [BlkW-1:0] blk;
  logic [BlkW-1:0] blk_in;
  logic [SetW-1:0] set_c;
  logic [TagW-1:0] tag_c;
  assign blk    = addr[AddrW-1:OffW];
  assign blk_in = byte_address[AddrW-1:OffW];
  assign set_c  = (SETS > 1) ? SetW'(blk_in % SETS) : '0;
  assign tag_c  = TagW'(blk_in / SETS);

  // Tag match and victim choice over the set.
  logic             m_hit;
  logic [WayW-1:0]  m_way, v_way;
  always_comb begin
    logic inv_found;
    logic [31:0] best;
    m_hit = 1'b0;
    m_way = '0;
    inv_found = 1'b0;
    v_way = '0;
    best = stamps[set_q][0];
    for (int w = 0; w < WAYS; w++) begin
      if (!m_hit && vld[set_q][w] && tags[set_q][w] == tag_q) begin
        m_hit = 1'b1;
        m_way = WayW'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vld[set_q][w]) begin
        inv_found = 1'b1;
        v_way = WayW'(w);
      end
    end
    if (!inv_found) begin
      for (int w = 1; w < WAYS; w++) begin
        if (stamps[set_q][w] < best) begin
          best = stamps[set_q][w];
          v_way = WayW'(w);
        end
      end
    end
  end

  function automatic logic [LAW-1:0] laddr(input logic [SetW-1:0] s,
                                           input logic [WayW-1:0] w,
                                           input logic [WOffW-1:0] i);
    return LAW'((32'(s) * WAYS + 32'(w)) * LW + 32'(i));
  endfunction

  logic [OffW-1:0] off;
  logic [WOffW-1:0] w0;
  assign off = addr[OffW-1:0];
  assign w0  = (LW > 1) ? WOffW'(off >> 2) : '0;

  // Data extraction from two consecutive line words (wraps within line).
  logic [31:0] ext;
  logic [5:0]  nbytes;
  always_comb begin
    logic [63:0] pair;
    logic [63:0] sh;
    pair = {lmem_q, lo_word};
    sh = pair >> {off[1:0], 3'b000};
    unique case (size)
      SZ_BYTE: begin ext = {24'd0, sh[7:0]};  nbytes = 6'd1; end
      SZ_HALF: begin ext = {16'd0, sh[15:0]}; nbytes = 6'd2; end
      SZ_WORD: begin ext = sh[31:0];          nbytes = 6'd4; end
      default: begin ext = '0;                nbytes = 6'd0; end
    endcase
  end

  // The output register is free when empty or being drained at this edge.
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && operation == OP_PRELOAD) begin
      bmem[MemW'(preload_index)] <= preload_value;
    end
    bmem_q <= bmem[bmem_ra];
    if (lmem_we) begin
      lmem[lmem_wa] <= bmem_q;
    end
    lmem_q <= lmem[lmem_ra];
  end

  // Fill address of the current word and read addresses.
  // The high line word is read in S_HIGH and held there through S_DATA.
  logic [WOffW-1:0] w1;
  assign w1 = (LW > 1) ? WOffW'(w0 + 1'b1) : '0;
  always_comb begin
    bmem_ra = MemW'((32'(blk) * LW + 32'(fcnt)) % MEM_WORDS);
    lmem_we = (state == S_FILL) && fvalid;
    lmem_wa = laddr(set_q, way_q, fidx);
    lmem_ra = (state == S_HIGH || state == S_DATA) ? laddr(set_q, way_q, w1)
            : laddr(set_q, way_q, w0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      stamp_ctr <= '0;
      hit_ctr <= '0;
      miss_ctr <= '0;
      byte_ctr <= '0;
      cyc_ctr <= '0;
      for (int s = 0; s < SETS; s++) begin
        vld[s] <= '0;
        for (int w = 0; w < WAYS; w++) begin
          tags[s][w] <= '1;
          stamps[s][w] <= '0;
        end
      end
    end else begin
      // Output beat is loaded from S_DATA or dropped once taken.
      if (state == S_DATA && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            addr <= byte_address;
            set_q <= set_c;
            tag_q <= tag_c;
            if (operation == OP_PRELOAD) begin
              // A preload returns no data and leaves the counters alone.
              size <= SZ_NONE;
              hit_q <= 1'b0;
              state <= S_DATA;
            end else begin
              size <= access_size;
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          // Set/tag registered; decide hit or victim.
          fcnt <= '0;
          fvalid <= 1'b0;
          fidx <= '0;
          hit_q <= m_hit;
          way_q <= m_hit ? m_way : v_way;
          stamps[set_q][m_hit ? m_way : v_way] <= stamp_ctr;
          stamp_ctr <= stamp_ctr + 32'd1;
          cyc_ctr <= cyc_ctr + (m_hit ? 32'd1 : 32'd1 + MissPenalty);
          if (m_hit) begin
            hit_ctr <= hit_ctr + 32'd1;
            state <= S_READ;
          end else begin
            miss_ctr <= miss_ctr + 32'd1;
            vld[set_q][v_way] <= 1'b1;
            tags[set_q][v_way] <= tag_q;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          // One backing word per cycle, written to the line in the cycle after its read.
          fvalid <= (32'(fcnt) < LW);
          fidx <= WOffW'(fcnt);
          fcnt <= fcnt + 1'b1;
          if (fvalid && 32'(fidx) == LW - 1) state <= S_READ;
        end
        S_READ: begin
          // Low line word is being read.
          state <= S_HIGH;
        end
        S_HIGH: begin
          // Low word arrives; high word is being read.
          lo_word <= lmem_q;
          state <= S_DATA;
        end
        S_DATA: begin
          // Both words stay stable here until the output register is free.
          if (out_free) begin
            state <= S_IDLE;
            hit <= hit_q;
            read_data <= ext;
            hit_total <= hit_ctr;
            miss_total <= miss_ctr;
            bytes_total <= byte_ctr + 32'(nbytes);
            byte_ctr <= byte_ctr + 32'(nbytes);
            cycle_total <= cyc_ctr;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
